@@ rtl/core/pdr_pkg.sv @@
// Shared constants, register codes and interface types of the PI duty regulator.
`default_nettype none

package pdr_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ADC_BITS_DEF = 12;

    // Full-scale voltage 3.3 V in Q(FRAC_BITS), rounded
    localparam int VFS_VAL = ((33 << FRAC_BITS) + 5) / 10;

    localparam int TGT_W  = 18;
    localparam int GAIN_W = 22;
    localparam int DUTY_W = FRAC_BITS + 1;
    localparam int PER_W  = 16;
    localparam int CMP_W  = 16;
    localparam int VOLT_W = $clog2(VFS_VAL + 1);
    localparam int ERR_W  = ((TGT_W > VOLT_W) ? TGT_W : VOLT_W) + 1;
    localparam int SUM_W  = 32;
    localparam int IDX_W  = 3;
    localparam int DATA_W = GAIN_W;

    localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KP       = 3'd1;
    localparam logic [IDX_W-1:0] REG_KI       = 3'd2;
    localparam logic [IDX_W-1:0] REG_DUTY_MIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_DUTY_MAX = 3'd4;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd5;

    localparam logic [TGT_W-1:0]  RST_TARGET   = 18'd131072;
    localparam logic [GAIN_W-1:0] RST_KP       = 22'd32768;
    localparam logic [GAIN_W-1:0] RST_KI       = 22'd655;
    localparam logic [DUTY_W-1:0] RST_DUTY_MIN = 17'd3277;
    localparam logic [DUTY_W-1:0] RST_DUTY_MAX = 17'd62259;
    localparam logic [PER_W-1:0]  RST_PERIOD   = 16'd999;
    localparam logic [DUTY_W-1:0] RST_DUTY     = DUTY_W'(1 << (FRAC_BITS - 1));

    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [PER_W-1:0]  period;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic step_err;
        logic step_mul;
        logic step_duty;
        logic load_out;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pdr_cfg_regs.sv @@
// Configuration register file of the PI duty regulator.
`default_nettype none

module pdr_cfg_regs
    import pdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET:   cfg_next.target   = cfg_data[TGT_W-1:0];
                REG_KP:       cfg_next.kp       = cfg_data[GAIN_W-1:0];
                REG_KI:       cfg_next.ki       = cfg_data[GAIN_W-1:0];
                REG_DUTY_MIN: cfg_next.duty_min = cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX: cfg_next.duty_max = cfg_data[DUTY_W-1:0];
                REG_PERIOD:   cfg_next.period   = cfg_data[PER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target   <= RST_TARGET;
            cfg_reg.kp       <= RST_KP;
            cfg_reg.ki       <= RST_KI;
            cfg_reg.duty_min <= RST_DUTY_MIN;
            cfg_reg.duty_max <= RST_DUTY_MAX;
            cfg_reg.period   <= RST_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pdr_ctrl.sv @@
// Sequencing state machine of the PI duty regulator.
`default_nettype none

module pdr_ctrl
    import pdr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output dp_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DUTY = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.step_err = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.step_mul = 1'b1;
                state_next   = ST_DUTY;
            end
            ST_DUTY:
            begin
                cmd.step_duty = 1'b1;
                state_next    = ST_CMP;
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pdr_datapath.sv @@
// Arithmetic datapath of the PI duty regulator: scaling, error, PI terms, clamp, compare.
`default_nettype none

module pdr_datapath
    import pdr_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    input  wire cfg_t                cfg,
    input  wire logic [ADC_BITS-1:0] adc_sample,
    output logic [CMP_W-1:0]         compare_value,
    output logic [DUTY_W-1:0]        duty_out,
    output logic                     clamped
);

    localparam int ADC_MAX  = (1 << ADC_BITS) - 1;
    localparam int VQ       = VFS_VAL / ADC_MAX;
    localparam int VR       = VFS_VAL % ADC_MAX;
    localparam int Y_W      = 2 * ADC_BITS;
    localparam int PK_W     = GAIN_W + 1 + ERR_W;
    localparam int PI_W     = GAIN_W + 1 + SUM_W;
    localparam int DELTA_W  = PI_W + 1;
    localparam int SH_W     = DELTA_W - FRAC_BITS;
    localparam int DT_W     = SH_W + 1;
    localparam int PROD_W   = DUTY_W + PER_W;
    localparam int CS_W     = PROD_W - FRAC_BITS;

    localparam logic [VOLT_W-1:0]   VQ_L   = VOLT_W'(VQ);
    localparam logic [Y_W-1:0]      VR_L   = Y_W'(VR);
    localparam logic [Y_W-1:0]      M_L    = Y_W'(ADC_MAX);
    localparam logic [Y_W-1:0]      M2_L   = Y_W'(2 * ADC_MAX);
    localparam logic [CMP_W-1:0]    CMP_SAT = '1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // volts = sample*VQ + floor(sample*VR / ADC_MAX)
    logic [VOLT_W-1:0]        sa_reg;
    logic [Y_W-1:0]           y_reg;
    logic [VOLT_W-1:0]        sa_next;
    logic [Y_W-1:0]           y_next;

    logic [Y_W:0]             ysum;
    logic [ADC_BITS-1:0]      q0;
    logic [Y_W-1:0]           rem;
    logic [1:0]               corr;
    logic [VOLT_W-1:0]        volts;
    logic signed [ERR_W-1:0]  err_w;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [SUM_W-1:0]  error_sum_reg;

    logic signed [PK_W-1:0]   pk_next;
    logic signed [PI_W-1:0]   pi_next;
    logic signed [PK_W-1:0]   pk_reg;
    logic signed [PI_W-1:0]   pi_reg;

    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] delta_sh;
    logic signed [DT_W-1:0]    duty_raw;
    logic signed [DT_W-1:0]    duty_clamp;
    logic                      hit;
    logic [DUTY_W-1:0]         duty_level_reg;
    logic                      hit_reg;

    logic [PROD_W-1:0]         cmp_prod;
    logic [CS_W-1:0]           cmp_full;
    logic [CMP_W-1:0]          cmp_sat;

    logic [CMP_W-1:0]          compare_value_reg;
    logic [DUTY_W-1:0]         duty_out_reg;
    logic                      clamped_reg;

    assign sa_next = VOLT_W'(adc_sample * VQ_L);
    assign y_next  = Y_W'(adc_sample) * VR_L;

    // Estimate low by at most one, then correct from the remainder
    assign ysum  = {1'b0, y_reg} + (Y_W+1)'(y_reg >> ADC_BITS);
    assign q0    = ysum[ADC_BITS +: ADC_BITS];
    assign rem   = y_reg - (Y_W'(q0) << ADC_BITS) + Y_W'(q0);
    assign corr  = (rem >= M2_L) ? 2'd2 : ((rem >= M_L) ? 2'd1 : 2'd0);
    assign volts = sa_reg + VOLT_W'(q0) + VOLT_W'(corr);

    assign err_w    = $signed(ERR_W'(cfg.target)) - $signed(ERR_W'(volts));
    assign sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err_w);

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign pk_next = $signed({1'b0, cfg.kp}) * err_reg;
    assign pi_next = $signed({1'b0, cfg.ki}) * error_sum_reg;

    assign delta    = DELTA_W'(pk_reg) + DELTA_W'(pi_reg);
    assign delta_sh = delta >>> FRAC_BITS;
    assign duty_raw = $signed(delta_sh[DT_W-1:0]) + $signed(DT_W'(duty_level_reg));

    // Upper limit first, lower limit wins
    always_comb
    begin
        duty_clamp = duty_raw;
        hit        = 1'b0;
        if (duty_raw > $signed(DT_W'(cfg.duty_max)))
        begin
            duty_clamp = $signed(DT_W'(cfg.duty_max));
            hit        = 1'b1;
        end
        if (duty_clamp < $signed(DT_W'(cfg.duty_min)))
        begin
            duty_clamp = $signed(DT_W'(cfg.duty_min));
            hit        = 1'b1;
        end
    end

    assign cmp_prod = PROD_W'(duty_level_reg) * PROD_W'(cfg.period);
    assign cmp_full = cmp_prod[FRAC_BITS +: CS_W];
    assign cmp_sat  = (cmp_full > CS_W'(CMP_SAT)) ? CMP_SAT : cmp_full[CMP_W-1:0];

    assign compare_value = compare_value_reg;
    assign duty_out      = duty_out_reg;
    assign clamped       = clamped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            duty_level_reg <= RST_DUTY;
        end
        else
        begin
            if (cmd.step_err)
            begin
                error_sum_reg <= sum_sat;
            end
            if (cmd.step_duty)
            begin
                duty_level_reg <= duty_clamp[DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sa_reg <= sa_next;
            y_reg  <= y_next;
        end
        if (cmd.step_err)
        begin
            err_reg <= err_w;
        end
        if (cmd.step_mul)
        begin
            pk_reg <= pk_next;
            pi_reg <= pi_next;
        end
        if (cmd.step_duty)
        begin
            hit_reg <= hit;
        end
        if (cmd.load_out)
        begin
            compare_value_reg <= cmp_sat;
            duty_out_reg      <= duty_level_reg;
            clamped_reg       <= hit_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pi_duty_regulator_core.sv @@
// Top level of the PI duty regulator: register file, sequencer and datapath.
//
// Usage:
//   Input channel (adc_sample, in_valid/in_stall): one converter sample per
//   control period. A transaction completes when in_valid is high and in_stall
//   is low. in_stall is low only while no sample is being processed.
//   Output channel (compare_value, duty_out, clamped, out_valid/out_stall):
//   one result per sample, held in an output register until taken.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data):
//   cfg_ready is always high; write only while the block is idle.
// Sequence: after the input transaction the sample passes the states ERR
//   (voltage remainder fix-up and error), MUL (the two gain multipliers),
//   DUTY (duty add and clamp) and CMP (compare multiply, out_valid set
//   once the output register is free). Only one sample is in flight: the
//   next is taken only after the sequencer is back in idle.
// Reset: integral cleared, duty set to half, registers to defaults, no result.
// A stalled result stays on the outputs; the next sample may still be taken
//   and runs up to the compare step, where it waits for the output register.
`default_nettype none

module pi_duty_regulator_core
    import pdr_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ADC_BITS-1:0] adc_sample,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [CMP_W-1:0]         compare_value,
    output logic [DUTY_W-1:0]        duty_out,
    output logic                     clamped,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [IDX_W-1:0]    cfg_index,
    input  wire logic [DATA_W-1:0]   cfg_data
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    pdr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pdr_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .adc_sample    (adc_sample),
        .compare_value (compare_value),
        .duty_out      (duty_out),
        .clamped       (clamped)
    );

endmodule

`default_nettype wire
